// ===== sv/thp_pkg.sv =====
// Shared types, widths and helpers for the triangle perimeter and area block.
// No dependencies; the top-level file refers to this package by scoped names.
`default_nettype none

package thp_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int FRAC_BITS       = 8;
    localparam int SIDE_WIDTH      = COORD_WIDTH + 1;
    localparam int RAD_WIDTH       = 2 * SIDE_WIDTH;
    localparam int PERIM_WIDTH     = 19;
    localparam int FACT_WIDTH      = PERIM_WIDTH;
    localparam int PROD_WIDTH      = 4 * FACT_WIDTH;
    localparam int AREA_SHIFT      = 2 * FRAC_BITS + 4;
    localparam int Q_WIDTH         = PROD_WIDTH - AREA_SHIFT;
    localparam int AREA_WIDTH      = 24;
    localparam int AREA_RAD_WIDTH  = 2 * AREA_WIDTH;
    localparam int NUM_SIDES       = 3;

    localparam logic [AREA_WIDTH-1:0] AREA_MAX = {AREA_WIDTH{1'b1}};

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
    } vertices_t;

    typedef struct packed {
        logic [SIDE_WIDTH-1:0]  side_ab;
        logic [SIDE_WIDTH-1:0]  side_ac;
        logic [SIDE_WIDTH-1:0]  side_bc;
        logic [PERIM_WIDTH-1:0] perimeter;
        logic [AREA_WIDTH-1:0]  area;
    } result_t;

    function automatic logic [COORD_WIDTH-1:0] abs_diff(
        input logic signed [COORD_WIDTH-1:0] p,
        input logic signed [COORD_WIDTH-1:0] q
    );
        logic [COORD_WIDTH:0] m;
        m = {p[COORD_WIDTH-1], p} - {q[COORD_WIDTH-1], q};
        if (m[COORD_WIDTH])
        begin
            m = ~m + 1'b1;
        end
        return m[COORD_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/thp_sqrt_cell.sv =====
// One step of the bitwise integer square root, applied to several lanes at once.
// Depends on nothing outside this file; chained by thp_sqrt_chain.
`default_nettype none

module thp_sqrt_cell #(
    parameter int RW    = 17,
    parameter int STEP  = 0,
    parameter int LANES = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [LANES-1:0][2*RW-1:0]     in_rem,
    input  logic [LANES-1:0][2*RW-1:0]     in_root,
    output logic                           out_valid,
    output logic [LANES-1:0][2*RW-1:0]     out_rem,
    output logic [LANES-1:0][2*RW-1:0]     out_root
);

    localparam logic [2*RW-1:0] BIT = (2*RW)'(1) << (2 * (RW - 1 - STEP));

    logic                       valid_reg;
    logic [LANES-1:0][2*RW-1:0] rem_reg;
    logic [LANES-1:0][2*RW-1:0] root_reg;
    logic [LANES-1:0][2*RW-1:0] rem_next;
    logic [LANES-1:0][2*RW-1:0] root_next;
    logic [LANES-1:0][2*RW-1:0] trial;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            trial[l] = in_root[l] + BIT;
            if (in_rem[l] >= trial[l])
            begin
                rem_next[l]  = in_rem[l] - trial[l];
                root_next[l] = (in_root[l] >> 1) + BIT;
            end
            else
            begin
                rem_next[l]  = in_rem[l];
                root_next[l] = in_root[l] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

`default_nettype wire

// ===== sv/thp_sqrt_chain.sv =====
// Row of square root cells, one result bit per cell, one new radicand per cycle while en is high.
// Depends on thp_sqrt_cell.
`default_nettype none

module thp_sqrt_chain #(
    parameter int RW    = 17,
    parameter int LANES = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [LANES-1:0][2*RW-1:0] rad,
    output logic                       out_valid,
    output logic [LANES-1:0][RW-1:0]   root
);

    logic                       valid_w [RW+1];
    logic [LANES-1:0][2*RW-1:0] rem_w   [RW+1];
    logic [LANES-1:0][2*RW-1:0] root_w  [RW+1];

    assign valid_w[0] = in_valid;
    assign rem_w[0]   = rad;
    assign root_w[0]  = '0;

    for (genvar k = 0; k < RW; k++)
    begin : g_cell
        thp_sqrt_cell #(
            .RW    (RW),
            .STEP  (k),
            .LANES (LANES)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_w[k]),
            .in_rem    (rem_w[k]),
            .in_root   (root_w[k]),
            .out_valid (valid_w[k+1]),
            .out_rem   (rem_w[k+1]),
            .out_root  (root_w[k+1])
        );
    end

    assign out_valid = valid_w[RW];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            root[l] = root_w[RW][l][RW-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/triangle_perimeter_area.sv =====
// One request is taken every cycle while the pipeline advances.
// The pipeline advances as a whole whenever the result register is empty or taken.
// Side roots run through 17 cells, the area root through 24 cells.
// Reset clears all valid flags; data registers are not reset.
// Depends on thp_pkg and thp_sqrt_chain.
`default_nettype none

module triangle_perimeter_area (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vertices_valid,
    output logic               vertices_ready,
    input  thp_pkg::vertices_t vertices,
    output logic               result_valid,
    input  logic               result_ready,
    output thp_pkg::result_t   result
);

    localparam int SW = thp_pkg::SIDE_WIDTH;
    localparam int PW = thp_pkg::PERIM_WIDTH;
    localparam int FW = thp_pkg::FACT_WIDTH;
    localparam int NS = thp_pkg::NUM_SIDES;
    localparam int AW = thp_pkg::AREA_WIDTH;

    typedef struct packed {
        logic [NS-1:0][SW-1:0] side;
        logic [PW-1:0]         perim;
        logic                  neg;
        logic                  sat;
    } meta_t;

    logic en;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic result_valid_reg;

    logic [2*NS-1:0][thp_pkg::COORD_WIDTH-1:0] s1_diff_reg;
    logic [NS-1:0][thp_pkg::RAD_WIDTH-1:0]     s2_rad_reg;
    logic                                      side_valid;
    logic [NS-1:0][SW-1:0]                     side_root;
    meta_t                                     s3_meta_reg, s4_meta_reg, s5_meta_reg;
    meta_t                                     s6_meta_reg, s7_meta_reg;
    logic [NS-1:0][FW-1:0]                     s4_fact_reg;
    logic [2*FW-1:0]                           s5_m1_reg, s5_m2_reg;
    logic [3:0][2*FW-1:0]                      s6_pp_reg;
    logic [thp_pkg::AREA_RAD_WIDTH-1:0]        s7_rad_reg;
    meta_t                                     meta_line_reg [AW];
    logic                                      area_valid;
    logic [0:0][AW-1:0]                        area_root;
    thp_pkg::result_t                          result_reg;

    logic [NS-1:0][FW-1:0]                     fact_next;
    logic [NS-1:0]                             fneg;
    logic [PW-1:0]                             twice;
    logic [thp_pkg::PROD_WIDTH-1:0]            prod;
    logic [thp_pkg::Q_WIDTH-1:0]               q;
    logic [AW-1:0]                             area_next;

    assign en             = !result_valid_reg || result_ready;
    assign vertices_ready = en;
    assign result_valid   = result_valid_reg;
    assign result         = result_reg;

    thp_sqrt_chain #(
        .RW    (SW),
        .LANES (NS)
    ) u_side_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .rad       (s2_rad_reg),
        .out_valid (side_valid),
        .root      (side_root)
    );

    thp_sqrt_chain #(
        .RW    (AW),
        .LANES (1)
    ) u_area_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s7_valid_reg),
        .rad       (s7_rad_reg),
        .out_valid (area_valid),
        .root      (area_root)
    );

    always_comb
    begin
        twice = '0;
        for (int i = 0; i < NS; i++)
        begin
            twice = PW'({s3_meta_reg.side[i], 1'b0});
            if (s3_meta_reg.perim >= twice)
            begin
                fact_next[i] = s3_meta_reg.perim - twice;
                fneg[i]      = 1'b0;
            end
            else
            begin
                fact_next[i] = twice - s3_meta_reg.perim;
                fneg[i]      = 1'b1;
            end
        end
    end

    always_comb
    begin
        prod = (thp_pkg::PROD_WIDTH'(s6_pp_reg[3]) << (2 * FW))
             + ((thp_pkg::PROD_WIDTH'(s6_pp_reg[1]) + thp_pkg::PROD_WIDTH'(s6_pp_reg[2])) << FW)
             + thp_pkg::PROD_WIDTH'(s6_pp_reg[0]);
        q = prod[thp_pkg::PROD_WIDTH-1:thp_pkg::AREA_SHIFT];
    end

    always_comb
    begin
        if (meta_line_reg[AW-1].neg)
        begin
            area_next = '0;
        end
        else if (meta_line_reg[AW-1].sat)
        begin
            area_next = thp_pkg::AREA_MAX;
        end
        else
        begin
            area_next = area_root[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            s6_valid_reg     <= 1'b0;
            s7_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg     <= vertices_valid;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= side_valid;
            s4_valid_reg     <= s3_valid_reg;
            s5_valid_reg     <= s4_valid_reg;
            s6_valid_reg     <= s5_valid_reg;
            s7_valid_reg     <= s6_valid_reg;
            result_valid_reg <= area_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_diff_reg[0] <= thp_pkg::abs_diff(vertices.a_x, vertices.b_x);
            s1_diff_reg[1] <= thp_pkg::abs_diff(vertices.a_y, vertices.b_y);
            s1_diff_reg[2] <= thp_pkg::abs_diff(vertices.a_x, vertices.c_x);
            s1_diff_reg[3] <= thp_pkg::abs_diff(vertices.a_y, vertices.c_y);
            s1_diff_reg[4] <= thp_pkg::abs_diff(vertices.b_x, vertices.c_x);
            s1_diff_reg[5] <= thp_pkg::abs_diff(vertices.b_y, vertices.c_y);

            for (int i = 0; i < NS; i++)
            begin
                s2_rad_reg[i] <=
                    thp_pkg::RAD_WIDTH'(s1_diff_reg[2*i]) * thp_pkg::RAD_WIDTH'(s1_diff_reg[2*i])
                  + thp_pkg::RAD_WIDTH'(s1_diff_reg[2*i+1])
                  * thp_pkg::RAD_WIDTH'(s1_diff_reg[2*i+1]);
            end

            s3_meta_reg.side  <= side_root;
            s3_meta_reg.perim <= PW'(side_root[0]) + PW'(side_root[1]) + PW'(side_root[2]);
            s3_meta_reg.neg   <= 1'b0;
            s3_meta_reg.sat   <= 1'b0;

            s4_meta_reg.side  <= s3_meta_reg.side;
            s4_meta_reg.perim <= s3_meta_reg.perim;
            s4_meta_reg.neg   <= ^fneg;
            s4_meta_reg.sat   <= s3_meta_reg.sat;
            s4_fact_reg       <= fact_next;

            s5_meta_reg <= s4_meta_reg;
            s5_m1_reg   <= (2*FW)'(s4_meta_reg.perim) * (2*FW)'(s4_fact_reg[0]);
            s5_m2_reg   <= (2*FW)'(s4_fact_reg[1]) * (2*FW)'(s4_fact_reg[2]);

            s6_meta_reg  <= s5_meta_reg;
            s6_pp_reg[0] <= (2*FW)'(s5_m1_reg[FW-1:0]) * (2*FW)'(s5_m2_reg[FW-1:0]);
            s6_pp_reg[1] <= (2*FW)'(s5_m1_reg[FW-1:0]) * (2*FW)'(s5_m2_reg[2*FW-1:FW]);
            s6_pp_reg[2] <= (2*FW)'(s5_m1_reg[2*FW-1:FW]) * (2*FW)'(s5_m2_reg[FW-1:0]);
            s6_pp_reg[3] <= (2*FW)'(s5_m1_reg[2*FW-1:FW]) * (2*FW)'(s5_m2_reg[2*FW-1:FW]);

            s7_meta_reg.side  <= s6_meta_reg.side;
            s7_meta_reg.perim <= s6_meta_reg.perim;
            s7_meta_reg.neg   <= s6_meta_reg.neg;
            s7_meta_reg.sat   <= |q[thp_pkg::Q_WIDTH-1:thp_pkg::AREA_RAD_WIDTH];
            s7_rad_reg        <= q[thp_pkg::AREA_RAD_WIDTH-1:0];

            meta_line_reg[0] <= s7_meta_reg;
            for (int k = 1; k < AW; k++)
            begin
                meta_line_reg[k] <= meta_line_reg[k-1];
            end

            result_reg.side_ab   <= meta_line_reg[AW-1].side[0];
            result_reg.side_ac   <= meta_line_reg[AW-1].side[1];
            result_reg.side_bc   <= meta_line_reg[AW-1].side[2];
            result_reg.perimeter <= meta_line_reg[AW-1].perim;
            result_reg.area      <= area_next;
        end
    end

endmodule

`default_nettype wire
